@@ src/ptdm_pkg.sv @@
`default_nettype none

package ptdm_pkg;

    localparam int MAX_TASKS_DEF  = 8;
    localparam int TICK_WIDTH_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int MASK_W         = 8;
    localparam int TIME_W         = 32;
    localparam int IDX_IN_W       = 3;
    localparam int CFG_W          = 4;
    localparam int IN_DATA_W      = 72;
    localparam int OUT_DATA_W     = 56;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_STATUS = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } seq_ctrl_t;

endpackage

`default_nettype wire

@@ src/ptdm_task_alu.sv @@
`default_nettype none

module ptdm_task_alu #(
    parameter int TICK_WIDTH = ptdm_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                  do_update,
    input  wire logic                  credit,
    input  wire logic [31:0]           time_now,
    input  wire logic [TICK_WIDTH-1:0] offset,
    input  wire logic [TICK_WIDTH-1:0] period,
    input  wire logic [TICK_WIDTH-1:0] deadline,
    input  wire logic [TICK_WIDTH-1:0] budget,
    input  wire logic [TICK_WIDTH-1:0] used_cur,
    input  wire logic [TICK_WIDTH:0]   dl_cur,
    input  wire logic [TICK_WIDTH-1:0] rel_cur,
    output logic      [TICK_WIDTH-1:0] used_new,
    output logic      [TICK_WIDTH:0]   dl_new,
    output logic      [TICK_WIDTH-1:0] rel_new,
    output logic                       ready_bit,
    output logic                       miss_bit
);

    import ptdm_pkg::*;

    logic [TICK_WIDTH-1:0] used_cred;

    always_comb
    begin
        used_cred = used_cur;
        if (credit && (used_cur != {TICK_WIDTH{1'b1}}))
        begin
            used_cred = used_cur + TICK_WIDTH'(1);
        end

        used_new = used_cred;
        dl_new   = dl_cur;
        rel_new  = rel_cur;
        miss_bit = 1'b0;

        if (do_update)
        begin
            if (dl_cur != '0)
            begin
                dl_new = dl_cur - (TICK_WIDTH + 1)'(1);
            end
            else if (used_cred != budget)
            begin
                miss_bit = 1'b1;
                used_new = budget;
            end

            if (rel_cur != '0)
            begin
                rel_new = rel_cur - TICK_WIDTH'(1);
            end
            else
            begin
                used_new = '0;
                rel_new  = (period != '0) ? period - TICK_WIDTH'(1) : '0;
                dl_new   = (deadline != '0) ? {1'b0, deadline - TICK_WIDTH'(1)} : '0;
            end
        end

        ready_bit = (time_now >= TIME_W'(offset)) && (used_new < budget);
    end

endmodule

`default_nettype wire

@@ src/ptdm_seq.sv @@
`default_nettype none

module ptdm_seq #(
    parameter int  MAX_TASKS = ptdm_pkg::MAX_TASKS_DEF,
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CNT_W     = $clog2(MAX_TASKS + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                out_free,
    input  wire logic [CNT_W-1:0]    active_n,
    output logic                     in_ready,
    output ptdm_pkg::seq_ctrl_t      ctrl,
    output logic      [IDX_W-1:0]    task_idx
);

    import ptdm_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              last_task;

    assign last_task = ((32'(idx_reg) + 32'd1) == 32'(active_n));
    assign task_idx  = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                begin
                    state_next = (active_n == '0) ? ST_FLUSH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_task)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
            end
            ST_RUN:
            begin
                ctrl.step = 1'b1;
            end
            ST_FLUSH:
            begin
                ctrl.finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

@@ src/periodic_task_deadline_monitor_unit.sv @@
`default_nettype none

// An accepted item steps the single shared task unit through N = min(tasks_in_use, MAX_TASKS) tasks, one task a
// cycle, and its result is then registered at the output once that is free; no new item is taken before that.
// The next item is accepted while a finished result still waits at the output register.
// Reset (rst_n, asynchronous, active low) clears time, the task timers, the used cycle
// counts and tasks_in_use; the task parameter tables stay undefined until loaded.

module periodic_task_deadline_monitor_unit #(
    parameter int MAX_TASKS  = ptdm_pkg::MAX_TASKS_DEF,
    parameter int TICK_WIDTH = ptdm_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ptdm_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // ran_valid, ran_task, entry_index, first_release, task_period,
    // relative_deadline, worst_case_cycles, zero fill.
    input  wire logic [ptdm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func.
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // ready_mask, miss_mask, all_met, now_ticks, zero fill.
    output logic      [ptdm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import ptdm_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [CFG_W-1:0]      tasks_in_use_reg;
    logic [CNT_W-1:0]      active_n;

    logic [TICK_WIDTH-1:0] offset_mem   [MAX_TASKS];
    logic [TICK_WIDTH-1:0] period_mem   [MAX_TASKS];
    logic [TICK_WIDTH-1:0] deadline_mem [MAX_TASKS];
    logic [TICK_WIDTH-1:0] budget_mem   [MAX_TASKS];
    logic [TICK_WIDTH-1:0] used_reg     [MAX_TASKS];
    logic [TICK_WIDTH:0]   dl_cnt_reg   [MAX_TASKS];
    logic [TICK_WIDTH-1:0] rel_cnt_reg  [MAX_TASKS];

    logic [TIME_W-1:0]     time_reg;
    logic [TIME_W-1:0]     time_next;
    func_t                 func_reg;
    logic                  ran_valid_reg;
    logic [IDX_IN_W-1:0]   ran_task_reg;
    logic [MASK_W-1:0]     ready_acc_reg;
    logic [MASK_W-1:0]     miss_acc_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    func_t                 in_func;
    logic                  in_ran_valid;
    logic [IDX_IN_W-1:0]   in_ran_task;
    logic [IDX_IN_W-1:0]   in_entry;
    logic [FIELD_W-1:0]    in_offset;
    logic [FIELD_W-1:0]    in_period;
    logic [FIELD_W-1:0]    in_deadline;
    logic [FIELD_W-1:0]    in_budget;

    seq_ctrl_t             ctrl;
    logic [IDX_W-1:0]      task_idx;
    logic                  out_free;
    logic                  load_wr;
    logic [IDX_W-1:0]      load_idx;
    logic [TICK_WIDTH-1:0] load_offset;
    logic [TICK_WIDTH-1:0] load_deadline;

    logic                  do_update;
    logic                  credit;
    logic [TICK_WIDTH-1:0] used_new;
    logic [TICK_WIDTH:0]   dl_new;
    logic [TICK_WIDTH-1:0] rel_new;
    logic                  ready_bit;
    logic                  miss_bit;
    logic [MASK_W-1:0]     bit_sel;

    assign in_func      = func_t'(s_axis_tuser);
    assign in_ran_valid = s_axis_tdata[0];
    assign in_ran_task  = s_axis_tdata[3:1];
    assign in_entry     = s_axis_tdata[6:4];
    assign in_offset    = s_axis_tdata[22:7];
    assign in_period    = s_axis_tdata[38:23];
    assign in_deadline  = s_axis_tdata[54:39];
    assign in_budget    = s_axis_tdata[70:55];

    assign active_n = (32'(tasks_in_use_reg) > 32'(MAX_TASKS)) ?
                      CNT_W'(MAX_TASKS) : CNT_W'(tasks_in_use_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign load_wr       = ctrl.accept && (in_func == FUNC_LOAD) &&
                           (32'(in_entry) < 32'(MAX_TASKS));
    assign load_idx      = IDX_W'(in_entry);
    assign load_offset   = TICK_WIDTH'(in_offset);
    assign load_deadline = TICK_WIDTH'(in_deadline);

    assign do_update = (func_reg == FUNC_TICK) || (func_reg == FUNC_START);
    assign credit    = (func_reg == FUNC_TICK) && ran_valid_reg &&
                       (32'(ran_task_reg) == 32'(task_idx));
    assign bit_sel   = MASK_W'(1) << task_idx;

    always_comb
    begin
        time_next = time_reg;
        if (ctrl.accept)
        begin
            unique case (in_func)
                FUNC_TICK:   time_next = time_reg + TIME_W'(1);
                FUNC_START:  time_next = '0;
                FUNC_LOAD,
                FUNC_STATUS: time_next = time_reg;
                default:     time_next = time_reg;
            endcase
        end
    end

    ptdm_seq #(
        .MAX_TASKS (MAX_TASKS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .active_n (active_n),
        .in_ready (s_axis_tready),
        .ctrl     (ctrl),
        .task_idx (task_idx)
    );

    ptdm_task_alu #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_alu (
        .do_update (do_update),
        .credit    (credit),
        .time_now  (time_reg),
        .offset    (offset_mem[task_idx]),
        .period    (period_mem[task_idx]),
        .deadline  (deadline_mem[task_idx]),
        .budget    (budget_mem[task_idx]),
        .used_cur  (used_reg[task_idx]),
        .dl_cur    (dl_cnt_reg[task_idx]),
        .rel_cur   (rel_cnt_reg[task_idx]),
        .used_new  (used_new),
        .dl_new    (dl_new),
        .rel_new   (rel_new),
        .ready_bit (ready_bit),
        .miss_bit  (miss_bit)
    );

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            offset_mem[load_idx]   <= load_offset;
            period_mem[load_idx]   <= TICK_WIDTH'(in_period);
            deadline_mem[load_idx] <= load_deadline;
            budget_mem[load_idx]   <= TICK_WIDTH'(in_budget);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                used_reg[i]    <= '0;
                dl_cnt_reg[i]  <= '0;
                rel_cnt_reg[i] <= '0;
            end
        end
        else if (load_wr)
        begin
            used_reg[load_idx]    <= '0;
            dl_cnt_reg[load_idx]  <= {1'b0, load_offset} + {1'b0, load_deadline};
            rel_cnt_reg[load_idx] <= load_offset;
        end
        else if (ctrl.step)
        begin
            used_reg[task_idx]    <= used_new;
            dl_cnt_reg[task_idx]  <= dl_new;
            rel_cnt_reg[task_idx] <= rel_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tasks_in_use_reg <= '0;
            time_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tasks_in_use_reg <= cfg_wdata;
            end
            time_reg <= time_next;
            if (ctrl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            func_reg      <= in_func;
            ran_valid_reg <= in_ran_valid;
            ran_task_reg  <= in_ran_task;
            ready_acc_reg <= '0;
            miss_acc_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            ready_acc_reg <= ready_acc_reg | (ready_bit ? bit_sel : '0);
            miss_acc_reg  <= miss_acc_reg | (miss_bit ? bit_sel : '0);
        end
        if (ctrl.finish)
        begin
            out_data_reg <= {7'd0, time_reg, (miss_acc_reg == '0), miss_acc_reg,
                             ready_acc_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again before the item was finished");

    a_all_met_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16] == (m_axis_tdata[15:8] == 8'd0)))
        else $error("all_met disagrees with miss_mask");

    a_step_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |-> (32'(task_idx) < 32'(active_n)))
        else $error("task index beyond the tasks in use");
`endif

endmodule

`default_nettype wire

@@ tb/periodic_task_deadline_monitor_unit_tb.sv @@
`timescale 1ns / 1ps

module periodic_task_deadline_monitor_unit_tb;

    import ptdm_pkg::*;

    localparam int TASK_SLOTS  = 8;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 117;

    typedef struct {
        func_t       kind;
        logic        ran_valid;
        logic [2:0]  ran_task;
        logic [2:0]  entry;
        logic [15:0] offset;
        logic [15:0] period;
        logic [15:0] deadline;
        logic [15:0] budget;
    } sched_item_t;

    typedef struct packed {
        logic [31:0] now_ticks;
        logic        all_met;
        logic [7:0]  miss_mask;
        logic [7:0]  ready_mask;
    } monitor_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    periodic_task_deadline_monitor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow of the task table, the job timers, time and the register.
    logic [15:0] rel_offset   [TASK_SLOTS];
    logic [15:0] period_len   [TASK_SLOTS];
    logic [15:0] deadline_len [TASK_SLOTS];
    logic [15:0] budget_len   [TASK_SLOTS];
    logic [15:0] cycles_used  [TASK_SLOTS];
    logic [16:0] due_in       [TASK_SLOTS];
    logic [15:0] release_in   [TASK_SLOTS];
    logic [31:0] now_count;
    logic [3:0]  tasks_setting;
    logic [7:0]  last_ready;

    monitor_status_t expected_status[$];
    int unsigned     error_count;
    int unsigned     burst_left;
    bit              steady_send;

    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned hold_left;
    int unsigned hold_requests;
    int unsigned hold_served;

    function automatic int unsigned active_tasks();
        return (tasks_setting > 4'd8) ? TASK_SLOTS : int'(tasks_setting);
    endfunction

    // One pass over the active tasks: deadlines first, then releases.
    function automatic logic [7:0] advance_schedule();
        logic [7:0] missed;
        missed = '0;
        for (int k = 0; k < active_tasks(); k++)
        begin
            if (due_in[k] != 17'd0)
                due_in[k] = due_in[k] - 17'd1;
            else if (cycles_used[k] != budget_len[k])
            begin
                missed[k] = 1'b1;
                cycles_used[k] = budget_len[k];
            end
            if (release_in[k] != 16'd0)
                release_in[k] = release_in[k] - 16'd1;
            else
            begin
                cycles_used[k] = 16'd0;
                release_in[k] = (period_len[k] != 16'd0) ? period_len[k] - 16'd1 : 16'd0;
                due_in[k] = (deadline_len[k] != 16'd0) ? {1'b0, deadline_len[k] - 16'd1}
                                                       : 17'd0;
            end
        end
        return missed;
    endfunction

    function automatic logic [7:0] ready_tasks();
        logic [7:0] ready;
        ready = '0;
        for (int k = 0; k < active_tasks(); k++)
            if ({16'd0, rel_offset[k]} <= now_count && cycles_used[k] < budget_len[k])
                ready[k] = 1'b1;
        return ready;
    endfunction

    function automatic monitor_status_t predict_status(input sched_item_t it);
        monitor_status_t res;
        logic [7:0]      missed;
        missed = '0;
        case (it.kind)
            FUNC_TICK:
            begin
                if (it.ran_valid && int'(it.ran_task) < active_tasks()
                    && cycles_used[it.ran_task] != 16'hFFFF)
                    cycles_used[it.ran_task] = cycles_used[it.ran_task] + 16'd1;
                now_count = now_count + 32'd1;
                missed = advance_schedule();
            end
            FUNC_LOAD:
            begin
                rel_offset[it.entry]   = it.offset;
                period_len[it.entry]   = it.period;
                deadline_len[it.entry] = it.deadline;
                budget_len[it.entry]   = it.budget;
                cycles_used[it.entry]  = 16'd0;
                due_in[it.entry]       = {1'b0, it.offset} + {1'b0, it.deadline};
                release_in[it.entry]   = it.offset;
            end
            FUNC_START:
            begin
                missed = advance_schedule();
                now_count = 32'd0;
            end
            default:
            begin
            end
        endcase
        res.ready_mask = ready_tasks();
        res.miss_mask  = missed;
        res.all_met    = (missed == 8'd0);
        res.now_ticks  = now_count;
        last_ready     = res.ready_mask;
        return res;
    endfunction

    function automatic sched_item_t random_item(input func_t kind);
        sched_item_t it;
        it.kind      = kind;
        it.ran_valid = 1'($urandom_range(0, 1));
        it.ran_task  = 3'($urandom_range(0, 7));
        it.entry     = 3'($urandom_range(0, 7));
        it.offset    = 16'($urandom_range(0, 65535));
        it.period    = 16'($urandom_range(0, 65535));
        it.deadline  = 16'($urandom_range(0, 65535));
        it.budget    = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic sched_item_t tick_item(input logic ran_valid, input logic [2:0] ran_task);
        sched_item_t it;
        it = random_item(FUNC_TICK);
        it.ran_valid = ran_valid;
        it.ran_task  = ran_task;
        return it;
    endfunction

    function automatic sched_item_t load_item(input logic [2:0] entry, input logic [15:0] offset,
                                              input logic [15:0] period,
                                              input logic [15:0] deadline,
                                              input logic [15:0] budget);
        sched_item_t it;
        it = random_item(FUNC_LOAD);
        it.entry    = entry;
        it.offset   = offset;
        it.period   = period;
        it.deadline = deadline;
        it.budget   = budget;
        return it;
    endfunction

    // Mostly short periods and small budgets so that releases and misses come often.
    function automatic sched_item_t plan_entry(input logic [2:0] entry);
        logic [15:0] offset;
        logic [15:0] period;
        logic [15:0] deadline;
        logic [15:0] budget;
        int unsigned roll;
        roll   = $urandom_range(0, 99);
        offset = 16'((roll < 85) ? $urandom_range(0, 8) : $urandom_range(0, 65535));
        roll   = $urandom_range(0, 99);
        period = 16'((roll < 80) ? $urandom_range(1, 24) : (roll < 90) ? 0
                                                                       : $urandom_range(0, 65535));
        roll     = $urandom_range(0, 99);
        deadline = 16'((roll < 85) ? $urandom_range(0, int'(period) % 24 + 4)
                                   : $urandom_range(0, 65535));
        roll   = $urandom_range(0, 99);
        budget = 16'((roll < 80) ? $urandom_range(0, 6) : (roll < 90) ? 65535
                                                                      : $urandom_range(0, 65535));
        return load_item(entry, offset, period, deadline, budget);
    endfunction

    // Usually credits a task that is ready, so that jobs finish as well as miss.
    function automatic sched_item_t plan_tick();
        int unsigned candidates[$];
        logic [2:0]  pick;
        for (int k = 0; k < TASK_SLOTS; k++)
            if (last_ready[k])
                candidates = {candidates, int'(k)};
        if (candidates.size() != 0 && $urandom_range(0, 9) < 8)
            pick = 3'(candidates[$urandom_range(0, candidates.size() - 1)]);
        else
            pick = 3'($urandom_range(0, 7));
        return tick_item($urandom_range(0, 9) != 0, pick);
    endfunction

    task automatic send_item(input sched_item_t it);
        s_axis_tdata  <= {1'b0, it.budget, it.deadline, it.period, it.offset,
                          it.entry, it.ran_task, it.ran_valid};
        s_axis_tuser  <= it.kind;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_status = {expected_status, predict_status(it)};
        if (burst_left > 0)
            burst_left--;
        else if (!steady_send)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_tasks_in_use(input logic [3:0] value);
        drain_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        tasks_setting = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_empty_schedule();
        set_tasks_in_use(4'd0);
        send_item(tick_item(1'b1, 3'd0));
        send_item(random_item(FUNC_STATUS));
        send_item(random_item(FUNC_START));
    endtask

    // Field extremes, zero period and deadline, and a budget that pins the used count.
    task automatic test_table_load();
        send_item(load_item(3'd0, 16'd0,     16'd0,     16'd0,     16'd1));
        send_item(load_item(3'd1, 16'd0,     16'hFFFF,  16'd1,     16'hFFFF));
        send_item(load_item(3'd2, 16'hFFFF,  16'd1,     16'hFFFF,  16'd0));
        send_item(load_item(3'd3, 16'd2,     16'd3,     16'd2,     16'd1));
        send_item(load_item(3'd4, 16'd1,     16'd4,     16'd4,     16'd2));
        send_item(load_item(3'd5, 16'd0,     16'd5,     16'd3,     16'd3));
        send_item(load_item(3'd6, 16'd3,     16'd2,     16'd0,     16'd1));
        send_item(load_item(3'd7, 16'd0,     16'd6,     16'd6,     16'd2));
    endtask

    task automatic test_edge_cases();
        set_tasks_in_use(4'd8);
        send_item(random_item(FUNC_START));
        send_item(tick_item(1'b1, 3'd1));
        send_item(tick_item(1'b1, 3'd1));
        send_item(tick_item(1'b1, 3'd1));
        send_item(tick_item(1'b1, 3'd7));
        send_item(tick_item(1'b0, 3'd0));
        send_item(random_item(FUNC_STATUS));
        set_tasks_in_use(4'd15);
        send_item(tick_item(1'b1, 3'd7));
        set_tasks_in_use(4'd2);
        send_item(tick_item(1'b1, 3'd5));
    endtask

    task automatic run_phase(input logic [3:0] setting);
        int unsigned roll;
        set_tasks_in_use(setting);
        for (int k = 0; k < TASK_SLOTS; k++)
            if ($urandom_range(0, 3) != 0)
                send_item(plan_entry(3'(k)));
        send_item(random_item(FUNC_START));
        repeat (PHASE_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                send_item(plan_tick());
            else if (roll < 86)
                send_item(random_item(FUNC_STATUS));
            else if (roll < 91)
                send_item(plan_entry(3'($urandom_range(0, 7))));
            else if (roll < 94)
                send_item(random_item(FUNC_LOAD));
            else if (roll < 96)
                send_item(random_item(FUNC_START));
            else
                send_item(random_item(FUNC_TICK));
        end
    endtask

    task automatic test_random_phases();
        logic [3:0] settings[$];
        settings = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd8, 4'd2, 4'd9, 4'd6, 4'd8, 4'd7, 4'd3};
        settings = {settings, 4'($urandom_range(0, 15))};
        foreach (settings[p])
            run_phase(settings[p]);
    endtask

    // The receiver holds off while items keep coming, so the input side must stall.
    task automatic test_output_backpressure();
        drain_results();
        hold_requests++;
        steady_send = 1'b1;
        repeat (24)
            send_item(plan_tick());
        steady_send = 1'b0;
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 48 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (rx_cycle % 5 == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        monitor_status_t got;
        monitor_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[48:0];
            if (expected_status.size() == 0)
            begin
                $error("result with none expected: ready_mask %h miss_mask %h now_ticks %0d",
                       got.ready_mask, got.miss_mask, got.now_ticks);
                error_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.ready_mask !== want.ready_mask)
                begin
                    $error("ready_mask: expected %h, got %h", want.ready_mask, got.ready_mask);
                    error_count++;
                end
                if (got.miss_mask !== want.miss_mask)
                begin
                    $error("miss_mask: expected %h, got %h", want.miss_mask, got.miss_mask);
                    error_count++;
                end
                if (got.all_met !== want.all_met)
                begin
                    $error("all_met: expected %b, got %b", want.all_met, got.all_met);
                    error_count++;
                end
                if (got.now_ticks !== want.now_ticks)
                begin
                    $error("now_ticks: expected %0d, got %0d", want.now_ticks, got.now_ticks);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("periodic_task_deadline_monitor_unit test failed");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < TASK_SLOTS; k++)
        begin
            rel_offset[k]   = '0;
            period_len[k]   = '0;
            deadline_len[k] = '0;
            budget_len[k]   = '0;
            cycles_used[k]  = '0;
            due_in[k]       = '0;
            release_in[k]   = '0;
        end
        now_count     = '0;
        tasks_setting = '0;
        last_ready    = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_schedule();
        test_table_load();
        test_edge_cases();
        test_random_phases();
        test_output_backpressure();

        drain_results();
        repeat (20)
            @(posedge clk);
        if (expected_status.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_status.size());
            error_count++;
        end
        if (error_count == 0)
            $display("periodic_task_deadline_monitor_unit test passed");
        else
            $display("periodic_task_deadline_monitor_unit test failed");
        $finish;
    end

endmodule
